// ----- design/lookahead_noise_gate_expander_defines.svh -----
// Assertion macros used by the checker file of the noise gate.
`ifndef LOOKAHEAD_NOISE_GATE_EXPANDER_DEFINES_SVH
`define LOOKAHEAD_NOISE_GATE_EXPANDER_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define LNGE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LNGE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/lnge_pkg.sv -----
// Types, constants and tables shared by the noise gate modules.
`timescale 1ns / 1ps
package lnge_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DELAY_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int LEVEL_W     = 23;
  localparam int GAIN_W      = 17;
  localparam int LOG_STEPS   = 16;

  localparam logic [GAIN_W-1:0]  UNITY     = 17'd65536;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL = 23'd84;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic        [LEVEL_W-1:0]     detector_level;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic        [GAIN_W-1:0]      applied_gain;
    logic        [2:0]             gate_phase;
    logic        [LEVEL_W-1:0]     input_peak;
    logic        [SAMPLE_BITS-1:0] output_peak;
  } result_t;

  typedef enum logic [2:0] {
    CFG_MODE      = 3'd0,
    CFG_THRESHOLD = 3'd1,
    CFG_SLOPE     = 3'd2,
    CFG_RANGE     = 3'd3,
    CFG_ATTACK    = 3'd4,
    CFG_RELEASE   = 3'd5,
    CFG_HOLD      = 3'd6,
    CFG_LOOKAHEAD = 3'd7
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_CLOSED  = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_HOLD    = 3'd2,
    PH_RELEASE = 3'd3,
    PH_OPEN    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOG,
    S_MUL,
    S_EXP,
    S_TGT,
    S_ENV,
    S_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       log_step;
    logic       mul;
    logic       exp_step;
    logic       tgt;
    logic       env;
    logic       apply;
    logic       done;
    logic [3:0] step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef logic [LOG_STEPS-1:0][29:0] root_table_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    x = x_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q0.30 factors 2^-(2^-k) for k = 1 to 16, each the root of the one before.
  function automatic root_table_t build_roots();
    root_table_t tab;
    logic [63:0] r;
    r = isqrt64(64'd1 << 59);
    for (int k = 0; k < LOG_STEPS; k++) begin
      tab[k] = r[29:0];
      r = isqrt64(r << 30);
    end
    return tab;
  endfunction

  localparam root_table_t ROOTS = build_roots();

endpackage

// ----- design/lnge_ctrl.sv -----
// Sequencer that steps one item through the gain computation.
`timescale 1ns / 1ps
module lnge_ctrl
  import lnge_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t     state;
  state_t     state_next;
  logic [3:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == S_LOG || state == S_EXP) begin
        count <= count + 4'd1;
      end else begin
        count <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (sample_valid) state_next = S_LOG;
      S_LOG:   if (count == 4'd15) state_next = S_MUL;
      S_MUL:   state_next = S_EXP;
      S_EXP:   if (count == 4'd15) state_next = S_TGT;
      S_TGT:   state_next = S_ENV;
      S_ENV:   state_next = S_APPLY;
      S_APPLY: state_next = S_DONE;
      S_DONE:  if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.step     = count;
    sample_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        sample_stall = 1'b0;
        cmd.load     = sample_valid;
      end
      S_LOG:   cmd.log_step = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_EXP:   cmd.exp_step = 1'b1;
      S_TGT:   cmd.tgt      = 1'b1;
      S_ENV:   cmd.env      = 1'b1;
      S_APPLY: cmd.apply    = 1'b1;
      S_DONE:  cmd.done     = status.out_free;
      default: cmd          = '0;
    endcase
  end

endmodule

// ----- design/lnge_dp.sv -----
// Datapath: registers, delay line, log/exp units, envelope and gain stage.
`timescale 1ns / 1ps
module lnge_dp
  import lnge_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sample_t     sample,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  // Configuration registers.
  logic                  expander_mode;
  logic [LEVEL_W-1:0]    threshold_level;
  logic [15:0]           expansion_slope;
  logic [GAIN_W-1:0]     range_gain;
  logic [15:0]           attack_coeff;
  logic [15:0]           release_coeff;
  logic [17:0]           hold_samples;
  logic [10:0]           lookahead_samples;

  // Envelope and meter state.
  logic [GAIN_W-1:0]     smoothed_gain;
  phase_t                phase;
  logic [17:0]           hold_remaining;
  logic [ADDR_W-1:0]     write_pointer;
  logic [ADDR_W:0]       fill;
  logic [LEVEL_W-1:0]    input_peak_reg;
  logic [SAMPLE_BITS-1:0] output_peak_reg;

  // Per-item working registers.
  logic [LEVEL_W-1:0]    level;
  logic [23:0]           mant_l;
  logic [23:0]           mant_t;
  logic [20:0]           log_l;
  logic [20:0]           log_t;
  logic [20:0]           expo;
  logic [30:0]           acc;
  logic [GAIN_W-1:0]     target;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  rd_ok;
  logic signed [SAMPLE_BITS-1:0] left_q;
  logic signed [SAMPLE_BITS-1:0] right_q;

  logic [2*SAMPLE_BITS-1:0] mem [DELAY_DEPTH];
  logic [2*SAMPLE_BITS-1:0] rd_data;

  function automatic logic [4:0] msb_index(input logic [LEVEL_W-1:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < LEVEL_W; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic logic [23:0] norm_mant(input logic [LEVEL_W-1:0] x,
                                            input logic [4:0] p);
    logic [23:0] m;
    m = {1'b0, x} << (5'd23 - p);
    return m;
  endfunction

  // Load-time values.
  logic [LEVEL_W-1:0] lvl_floor;
  logic [LEVEL_W-1:0] thr_floor;
  logic [4:0]         p_l;
  logic [4:0]         p_t;
  logic [ADDR_W-1:0]  la_eff;
  logic [ADDR_W-1:0]  rd_new;
  logic [ADDR_W:0]    fill_new;

  always_comb begin
    lvl_floor = (sample.detector_level < MIN_LEVEL) ? MIN_LEVEL : sample.detector_level;
    thr_floor = (threshold_level < MIN_LEVEL) ? MIN_LEVEL : threshold_level;
    p_l       = msb_index(lvl_floor);
    p_t       = msb_index(thr_floor);
    if (32'(lookahead_samples) >= DELAY_DEPTH) begin
      la_eff = ADDR_W'(DELAY_DEPTH - 1);
    end else begin
      la_eff = ADDR_W'(lookahead_samples);
    end
    rd_new   = write_pointer - la_eff;
    fill_new = (fill == (ADDR_W+1)'(DELAY_DEPTH)) ? fill : fill + 1'b1;
  end

  // Squaring step of the logarithm on both mantissas.
  logic [47:0] sq_l;
  logic [47:0] sq_t;
  logic [3:0]  bit_pos;
  assign sq_l    = mant_l * mant_l;
  assign sq_t    = mant_t * mant_t;
  assign bit_pos = 4'd15 - cmd.step;

  logic [20:0] log_diff;
  logic [36:0] slope_prod;
  assign log_diff   = (log_t > log_l) ? log_t - log_l : '0;
  assign slope_prod = log_diff * expansion_slope;

  logic [60:0] exp_prod;
  assign exp_prod = acc * ROOTS[cmd.step];

  logic [5:0]        exp_shift;
  logic [GAIN_W-1:0] exp_gain;
  assign exp_shift = 6'd14 + {1'b0, expo[20:16]};
  assign exp_gain  = GAIN_W'(acc >> exp_shift);

  // Envelope update.
  logic [GAIN_W-1:0] gain_next;
  phase_t            phase_next;
  logic [17:0]       hold_next;
  logic [GAIN_W-1:0] delta;
  logic [GAIN_W-1:0] coeff_c;
  logic [33:0]       step_prod;
  logic [GAIN_W-1:0] step_amt;
  logic [23:0]       gain_x100;
  logic [23:0]       range_x101;

  always_comb begin
    gain_next  = smoothed_gain;
    phase_next = phase;
    hold_next  = hold_remaining;
    if (target > smoothed_gain) begin
      delta   = target - smoothed_gain;
      coeff_c = UNITY - {1'b0, attack_coeff};
    end else begin
      delta   = smoothed_gain - target;
      coeff_c = UNITY - {1'b0, release_coeff};
    end
    step_prod  = delta * coeff_c + 34'd65535;
    step_amt   = step_prod[32:16];
    gain_x100  = smoothed_gain * 7'd100;
    range_x101 = range_gain * 7'd101;
    if (target > smoothed_gain) begin
      phase_next = PH_ATTACK;
      hold_next  = '0;
      gain_next  = smoothed_gain + step_amt;
    end else if (target < smoothed_gain) begin
      if (phase_next == PH_ATTACK || phase_next == PH_OPEN) begin
        phase_next = PH_HOLD;
        hold_next  = hold_samples;
      end
      if (phase_next == PH_HOLD) begin
        if (hold_next <= 18'd1) begin
          hold_next  = '0;
          phase_next = PH_RELEASE;
        end else begin
          hold_next = hold_next - 18'd1;
        end
      end
      if (phase_next == PH_RELEASE) begin
        gain_next = smoothed_gain - step_amt;
      end
    end else begin
      if (gain_x100 >= 24'd6488064) begin
        phase_next = PH_OPEN;
      end else if (gain_x100 <= range_x101) begin
        phase_next = PH_CLOSED;
      end
    end
  end

  // Gain stage: round half up, then saturate.
  localparam int PW = SAMPLE_BITS + GAIN_W + 2;
  localparam logic signed [PW-17:0] Q_HI = (PW-16)'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PW-17:0] Q_LO = (PW-16)'(-(1 << (SAMPLE_BITS - 1)));

  logic signed [SAMPLE_BITS-1:0] src_l;
  logic signed [SAMPLE_BITS-1:0] src_r;
  logic signed [PW-1:0]          prod_l;
  logic signed [PW-1:0]          prod_r;
  logic signed [PW-17:0]         q_l;
  logic signed [PW-17:0]         q_r;
  logic signed [SAMPLE_BITS-1:0] sat_l;
  logic signed [SAMPLE_BITS-1:0] sat_r;
  logic [SAMPLE_BITS-1:0]        mag_l;
  logic [SAMPLE_BITS-1:0]        mag_r;
  logic [SAMPLE_BITS-1:0]        mag_max;

  always_comb begin
    src_l  = rd_ok ? rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    src_r  = rd_ok ? rd_data[SAMPLE_BITS-1:0] : '0;
    prod_l = PW'(src_l) * PW'($signed({1'b0, smoothed_gain})) + PW'(32768);
    prod_r = PW'(src_r) * PW'($signed({1'b0, smoothed_gain})) + PW'(32768);
    q_l    = prod_l[PW-1:16];
    q_r    = prod_r[PW-1:16];
    if (q_l > Q_HI)      sat_l = SAMPLE_BITS'(Q_HI);
    else if (q_l < Q_LO) sat_l = SAMPLE_BITS'(Q_LO);
    else                 sat_l = SAMPLE_BITS'(q_l);
    if (q_r > Q_HI)      sat_r = SAMPLE_BITS'(Q_HI);
    else if (q_r < Q_LO) sat_r = SAMPLE_BITS'(Q_LO);
    else                 sat_r = SAMPLE_BITS'(q_r);
    mag_l   = sat_l[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sat_l) : SAMPLE_BITS'(sat_l);
    mag_r   = sat_r[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sat_r) : SAMPLE_BITS'(sat_r);
    mag_max = (mag_r > mag_l) ? mag_r : mag_l;
  end

  // Delay line.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[write_pointer] <= {sample.left_in, sample.right_in};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expander_mode     <= 1'b0;
      threshold_level   <= 23'd83886;
      expansion_slope   <= 16'd32768;
      range_gain        <= 17'd1;
      attack_coeff      <= 16'd64000;
      release_coeff     <= 16'd65400;
      hold_samples      <= 18'd0;
      lookahead_samples <= 11'd96;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_MODE:      expander_mode     <= cfg_data[0];
        CFG_THRESHOLD: threshold_level   <= cfg_data[22:0];
        CFG_SLOPE:     expansion_slope   <= cfg_data[15:0];
        CFG_RANGE:     range_gain        <= cfg_data[16:0];
        CFG_ATTACK:    attack_coeff      <= cfg_data[15:0];
        CFG_RELEASE:   release_coeff     <= cfg_data[15:0];
        CFG_HOLD:      hold_samples      <= cfg_data[17:0];
        CFG_LOOKAHEAD: lookahead_samples <= cfg_data[10:0];
        default:       expander_mode     <= expander_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_gain   <= 17'd1;
      phase           <= PH_CLOSED;
      hold_remaining  <= '0;
      write_pointer   <= '0;
      fill            <= '0;
      input_peak_reg  <= '0;
      output_peak_reg <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (cmd.load) begin
        write_pointer <= write_pointer + 1'b1;
        fill          <= fill_new;
        if (sample.detector_level > input_peak_reg) begin
          input_peak_reg <= sample.detector_level;
        end
      end
      if (cmd.env) begin
        smoothed_gain  <= gain_next;
        phase          <= phase_next;
        hold_remaining <= hold_next;
      end
      if (cmd.apply && mag_max > output_peak_reg) begin
        output_peak_reg <= mag_max;
      end
      if (cmd.done) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      level   <= sample.detector_level;
      mant_l  <= norm_mant(lvl_floor, p_l);
      mant_t  <= norm_mant(thr_floor, p_t);
      log_l   <= {p_l, 16'b0};
      log_t   <= {p_t, 16'b0};
      rd_addr <= rd_new;
      rd_ok   <= {1'b0, rd_new} < fill_new;
    end
    if (cmd.log_step) begin
      if (sq_l[47]) begin
        mant_l         <= sq_l[47:24];
        log_l[bit_pos] <= 1'b1;
      end else begin
        mant_l <= sq_l[46:23];
      end
      if (sq_t[47]) begin
        mant_t         <= sq_t[47:24];
        log_t[bit_pos] <= 1'b1;
      end else begin
        mant_t <= sq_t[46:23];
      end
    end
    if (cmd.mul) begin
      expo <= slope_prod[36:16];
      acc  <= 31'h4000_0000;
    end
    if (cmd.exp_step && expo[bit_pos]) begin
      acc <= exp_prod[60:30];
    end
    if (cmd.tgt) begin
      if (level >= threshold_level) begin
        target <= UNITY;
      end else if (!expander_mode) begin
        target <= range_gain;
      end else begin
        target <= (exp_gain > range_gain) ? exp_gain : range_gain;
      end
    end
    if (cmd.apply) begin
      left_q  <= sat_l;
      right_q <= sat_r;
    end
    if (cmd.done) begin
      result.left_out     <= left_q;
      result.right_out    <= right_q;
      result.applied_gain <= smoothed_gain;
      result.gate_phase   <= phase;
      result.input_peak   <= input_peak_reg;
      result.output_peak  <= output_peak_reg;
    end
  end

  assign status.out_free = !result_valid || !result_stall;

endmodule

// ----- design/lookahead_noise_gate_expander.sv -----
// Top level of the look-ahead stereo noise gate and downward expander.
//
// Input channel: sample_valid / sample_stall with one stereo pair and its
// detector level per beat. Output channel: result_valid / result_stall with
// the delayed, gain-scaled pair, the applied gain, the gate phase and the
// two peak meters. Configuration is written through cfg_write, cfg_index and
// cfg_data; the user must do so only while the block is idle, which the
// block itself does not enforce. The result is registered after 16 squaring
// steps of the logarithm unit, one slope multiply, 16 steps of the
// exponential unit, then target, envelope, gain and output.
// The next item can be accepted in the cycle after the result is registered,
// so the block takes no new item before it is through with the last one.
// A result held by result_stall stalls the sequencer only when the next
// result is ready to be written.
// Reset restores the register defaults, closes the gate and empties the
// delay line; entries not yet written since reset read as silence, tracked
// by a fill count, so no clearing pass is needed.
`timescale 1ns / 1ps
module lookahead_noise_gate_expander
  import lnge_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lnge_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  lnge_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- design/lnge_checker.sv -----
// Port-level checks of the noise gate and their binding to the top level.
`timescale 1ns / 1ps
`include "lookahead_noise_gate_expander_defines.svh"
module lnge_checker
  import lnge_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  `LNGE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result after reset")
  `LNGE_ASSERT(a_busy_after_beat, clk, rst, sample_valid && !sample_stall |=> sample_stall, "second beat accepted while busy")
  `LNGE_ASSERT(a_result_held, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
  `LNGE_ASSERT(a_phase_code, clk, rst, result_valid |-> result.gate_phase <= 3'd4, "bad gate phase")

endmodule

bind lookahead_noise_gate_expander lnge_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- test/tb.sv -----
// Self-checking testbench for the look-ahead stereo noise gate and downward expander.
`timescale 1ns / 1ps
module tb;
  import lnge_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  // Mirrors the gate: configuration, envelope state, delay line and meters.
  class gate_scoreboard;
    logic        mode;
    logic [22:0] thresh;
    logic [15:0] slope;
    logic [16:0] floor_gain;
    logic [15:0] att_coef;
    logic [15:0] rel_coef;
    logic [17:0] hold_len;
    logic [10:0] delay_len;
    logic [16:0] gain;
    phase_t      ph;
    logic [17:0] hold_left;
    logic [10:0] wr_ptr;
    logic signed [SAMPLE_BITS-1:0] ring_l [DELAY_DEPTH];
    logic signed [SAMPLE_BITS-1:0] ring_r [DELAY_DEPTH];
    logic [22:0] in_peak;
    logic [23:0] out_peak;
    result_t     pending [$];
    int          errors;

    function new();
      mode = 1'b0; thresh = 23'd83886; slope = 16'd32768; floor_gain = 17'd1;
      att_coef = 16'd64000; rel_coef = 16'd65400; hold_len = '0; delay_len = 11'd96;
      gain = floor_gain; ph = PH_CLOSED; hold_left = '0; wr_ptr = '0;
      foreach (ring_l[i]) begin
        ring_l[i] = '0;
        ring_r[i] = '0;
      end
      in_peak = '0; out_peak = '0; errors = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [22:0] v);
      case (idx)
        CFG_MODE:      mode = v[0];
        CFG_THRESHOLD: thresh = v[22:0];
        CFG_SLOPE:     slope = v[15:0];
        CFG_RANGE:     floor_gain = v[16:0];
        CFG_ATTACK:    att_coef = v[15:0];
        CFG_RELEASE:   rel_coef = v[15:0];
        CFG_HOLD:      hold_len = v[17:0];
        default:       delay_len = v[10:0];
      endcase
    endfunction

    function logic [63:0] int_root(logic [63:0] x_in);
      logic [63:0] x, r, b;
      x = x_in; r = '0; b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Integer part from the leading one, fraction by repeated squaring.
    function logic [31:0] level_log2(logic [22:0] x_in);
      logic [22:0] x;
      int          p;
      logic [63:0] m;
      logic [31:0] res;
      x = (x_in == 0) ? 23'd1 : x_in;
      p = 0;
      while (p < 22 && (x >> (p + 1)) != 0) p++;
      m = 64'(x) << (23 - p);
      res = 32'(p) << 16;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 23;
        if (m >= (64'd1 << 24)) begin
          m = m >> 1;
          res[15-k] = 1'b1;
        end
      end
      return res;
    endfunction

    function logic [63:0] attenuation(logic [63:0] e);
      logic [63:0] n, acc, r;
      n = e >> 16;
      acc = 64'd1 << 30;
      r = int_root(64'd1 << 59);
      for (int k = 1; k <= 16; k++) begin
        if (e[16-k]) acc = (acc * r) >> 30;
        r = int_root(r << 30);
      end
      if (n + 14 >= 63) return '0;
      return acc >> (14 + n);
    endfunction

    function logic [16:0] wanted_gain(logic [22:0] level);
      logic [22:0] l, t;
      logic [63:0] ll, lt, d, g;
      if (level >= thresh) return UNITY;
      if (!mode) return floor_gain;
      l = (level < MIN_LEVEL) ? MIN_LEVEL : level;
      t = (thresh < MIN_LEVEL) ? MIN_LEVEL : thresh;
      ll = 64'(level_log2(l));
      lt = 64'(level_log2(t));
      d = (lt > ll) ? lt - ll : 64'd0;
      g = attenuation((d * slope) >> 16);
      return (g > floor_gain) ? g[16:0] : floor_gain;
    endfunction

    function void follow(logic [16:0] tgt);
      logic [63:0] delta, step;
      if (tgt > gain) begin
        ph = PH_ATTACK;
        hold_left = '0;
        delta = tgt - gain;
        step = (delta * (64'd65536 - att_coef) + 64'd65535) >> 16;
        gain = gain + step[16:0];
      end else if (tgt < gain) begin
        if (ph == PH_ATTACK || ph == PH_OPEN) begin
          ph = PH_HOLD;
          hold_left = hold_len;
        end
        if (ph == PH_HOLD) begin
          if (hold_left <= 18'd1) begin
            hold_left = '0;
            ph = PH_RELEASE;
          end else begin
            hold_left = hold_left - 18'd1;
          end
        end
        if (ph == PH_RELEASE) begin
          delta = gain - tgt;
          step = (delta * (64'd65536 - rel_coef) + 64'd65535) >> 16;
          gain = gain - step[16:0];
        end
      end else begin
        if (64'(gain) * 100 >= 64'd99 * 64'd65536) ph = PH_OPEN;
        else if (64'(gain) * 100 <= 64'(floor_gain) * 101) ph = PH_CLOSED;
      end
    endfunction

    // Round half up, then saturate to the sample range.
    function logic signed [SAMPLE_BITS-1:0] scaled(logic signed [SAMPLE_BITS-1:0] s,
                                                  output longint mag);
      longint p, q;
      p = longint'(s) * longint'(gain) + 32768;
      q = p >>> 16;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      mag = (q < 0) ? -q : q;
      return q[SAMPLE_BITS-1:0];
    endfunction

    function void note_input(sample_t s);
      result_t     e;
      logic [10:0] rd;
      longint      ml, mr;
      if (s.detector_level > in_peak) in_peak = s.detector_level;
      follow(wanted_gain(s.detector_level));
      ring_l[wr_ptr] = s.left_in;
      ring_r[wr_ptr] = s.right_in;
      rd = wr_ptr - delay_len;
      e.left_out = scaled(ring_l[rd], ml);
      e.right_out = scaled(ring_r[rd], mr);
      if (mr > ml) ml = mr;
      if (ml > out_peak) out_peak = ml[23:0];
      wr_ptr = wr_ptr + 11'd1;
      e.applied_gain = gain;
      e.gate_phase = ph;
      e.input_peak = in_peak;
      e.output_peak = out_peak;
      pending.push_back(e);
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
    endfunction

    function void check_result(result_t r);
      result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing expected: %h", r);
        return;
      end
      e = pending.pop_front();
      if (r.left_out !== e.left_out) report("left_out", e.left_out, r.left_out);
      if (r.right_out !== e.right_out) report("right_out", e.right_out, r.right_out);
      if (r.applied_gain !== e.applied_gain)
        report("applied_gain", e.applied_gain, r.applied_gain);
      if (r.gate_phase !== e.gate_phase) report("gate_phase", e.gate_phase, r.gate_phase);
      if (r.input_peak !== e.input_peak) report("input_peak", e.input_peak, r.input_peak);
      if (r.output_peak !== e.output_peak)
        report("output_peak", e.output_peak, r.output_peak);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  sample_t     sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = CFG_MODE;
  logic [22:0] cfg_data = '0;

  gate_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  lookahead_noise_gate_expander dut (
    .clk, .rst, .sample_valid, .sample_stall, .sample,
    .result_valid, .result_stall, .result, .cfg_write, .cfg_index, .cfg_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) sb.check_result(result);
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_item(sample_t s);
    while ($urandom_range(0, 99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    sb.note_input(s);
  endtask

  // Lets every expected beat arrive, then waits on so that a stray beat is still seen.
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [22:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  function automatic logic [23:0] audio_value();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic sample_t make_item(logic [22:0] level);
    sample_t s;
    s.left_in = audio_value();
    s.right_in = audio_value();
    s.detector_level = level;
    return s;
  endfunction

  task automatic directed_items();
    logic [22:0] t;
    t = sb.thresh;
    send_item('{24'sh7FFFFF, 24'sh800000, 23'd0});
    send_item('{24'sh800000, 24'sh7FFFFF, 23'h7FFFFF});
    send_item('{24'sh000000, -24'sd1, 23'd83});
    send_item(make_item(23'd84));
    send_item(make_item(t));
    if (t != 0) send_item(make_item(t - 23'd1));
    send_item(make_item(23'd0));
  endtask

  // Loud bursts followed by quiet stretches drive attack, hold and release.
  task automatic burst_traffic(int count, bit pause_once);
    int          sent, run;
    bit          loud;
    logic [22:0] lvl;
    sent = 0;
    loud = 1'b1;
    while (sent < count) begin
      run = loud ? $urandom_range(1, 30) : $urandom_range(1, 60);
      for (int i = 0; i < run && sent < count; i++) begin
        if ($urandom_range(0, 9) == 0) lvl = 23'($urandom());
        else if (loud) lvl = 23'($urandom_range(sb.thresh, 23'h7FFFFF));
        else lvl = (sb.thresh == 0) ? 23'd0 : 23'($urandom_range(0, sb.thresh - 1));
        send_item(make_item(lvl));
        sent++;
        if (pause_once && sent == count / 2) begin
          sample_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      loud = !loud;
    end
  endtask

  initial begin
    logic [22:0] v [8];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();
    burst_traffic(150, 1'b0);
    for (int p = 1; p <= 8; p++) begin
      drain();
      v[CFG_MODE] = 23'($urandom_range(0, 1));
      v[CFG_THRESHOLD] = 23'($urandom_range(100, 4000000));
      v[CFG_SLOPE] = 23'($urandom_range(0, 16'hFFFF));
      v[CFG_RANGE] = 23'($urandom_range(0, 17'h1FFFF));
      v[CFG_ATTACK] = 23'($urandom_range(0, 16'hFFFF));
      v[CFG_RELEASE] = 23'($urandom_range(0, 16'hFFFF));
      v[CFG_HOLD] = 23'($urandom_range(0, 40));
      v[CFG_LOOKAHEAD] = 23'($urandom_range(0, 11'h7FF));
      case (p)
        1: begin
          v[CFG_MODE] = 0; v[CFG_THRESHOLD] = 23'h100000; v[CFG_RANGE] = 0;
          v[CFG_ATTACK] = 0; v[CFG_RELEASE] = 0; v[CFG_HOLD] = 0; v[CFG_LOOKAHEAD] = 0;
        end
        2: begin
          v[CFG_MODE] = 1; v[CFG_THRESHOLD] = 23'h7FFFFF; v[CFG_SLOPE] = 62259;
          v[CFG_RANGE] = 1; v[CFG_ATTACK] = 16'hFFFF; v[CFG_RELEASE] = 16'hFFFF;
          v[CFG_HOLD] = 1; v[CFG_LOOKAHEAD] = 11'h7FF;
        end
        3: begin
          // Threshold below the level floor: expander gain is unity, range wins.
          v[CFG_MODE] = 1; v[CFG_THRESHOLD] = 50; v[CFG_SLOPE] = 16'hFFFF;
          v[CFG_RANGE] = 17'h1FFFF; v[CFG_LOOKAHEAD] = 1;
        end
        4: begin
          v[CFG_MODE] = 1; v[CFG_RANGE] = 0; v[CFG_ATTACK] = 60000;
          v[CFG_RELEASE] = 64000; v[CFG_HOLD] = 20;
        end
        5: begin
          v[CFG_MODE] = 0; v[CFG_RANGE] = 17'h1FFFF; v[CFG_HOLD] = 18'h3FFFF;
        end
        6: begin
          v[CFG_MODE] = 1; v[CFG_THRESHOLD] = 0; v[CFG_RANGE] = 65536;
        end
        default: ;
      endcase
      for (int i = 0; i < 8; i++) write_reg(cfg_index_t'(i), v[i]);
      cfg_write <= 1'b0;
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      if (p == 2 || p == 4) directed_items();
      burst_traffic(180, p == 4);
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/lnge_pkg.sv
design/lnge_ctrl.sv
design/lnge_dp.sv
design/lookahead_noise_gate_expander.sv
design/lnge_checker.sv
test/tb.sv
